### sv/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants for the positional stereo gain block
// Holds the register indexes, the arctangent table, the cell data types and
// the pipeline depth figures used by the top level and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

  // Default coordinate width of camera and source positions.
  localparam int unsigned COORD_WIDTH_DEF = 24;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W    = 3;
  localparam logic [2:0]  REG_CAMERA_X = 3'd0;
  localparam logic [2:0]  REG_CAMERA_Y = 3'd1;
  localparam logic [2:0]  REG_CAMERA_Z = 3'd2;
  localparam logic [2:0]  REG_VIEW_COS = 3'd3;
  localparam logic [2:0]  REG_VIEW_SIN = 3'd4;

  // Reset value of the heading cosine (one in Q1.15).
  localparam logic signed [15:0] VIEW_COS_RST = 16'sd32767;

  // Cell counts of the three chains.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 15;
  localparam int unsigned DIV_STEPS    = 16;

  // Total register stages from input capture to the last product stage.
  localparam int unsigned PIPE_DEPTH = 43;

  // Beyond this rotated component magnitude the source is silent.
  localparam logic [13:0] FAR_LIMIT = 14'd10512;

  // Attenuation dividend, 1224 in Q0.16.
  localparam logic [26:0] ATTEN_NUM = 27'd80216064;

  // Reciprocal of 4000 scaled by 2^38, rounded up.
  localparam logic [26:0] RECIP_4000 = 27'd68719477;
  localparam int unsigned RECIP_SHIFT = 38;

  // Pan constants in Q0.16.
  localparam logic [15:0] PAN_BASE  = 16'd45875;
  localparam logic [15:0] PAN_RIGHT = 16'd19661;
  localparam logic [15:0] PAN_LEFT  = 16'd39322;

  // CORDIC rotation data handed from cell to cell.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [17:0] z;
  } cordic_t;

  // Square root data: remaining radicand and partial root.
  typedef struct packed {
    logic [29:0] rad;
    logic [29:0] root;
  } sqrt_t;

  // Division data: partial remainder, divisor and quotient bits.
  typedef struct packed {
    logic [26:0] rem;
    logic [14:0] dvsr;
    logic [15:0] quo;
  } divq_t;

  // Per-source side data carried along the pipeline.
  typedef struct packed {
    logic        np;
    logic        far;
    logic        xpos;
    logic [16:0] v0;
    logic [15:0] npg;
  } sb_t;

  // Left and right pan factors.
  typedef struct packed {
    logic [15:0] lq;
    logic [16:0] rq;
  } pan_t;

  // Arctangent of 2^-i in Q0.16 quarter turns.
  function automatic logic [15:0] atan_q16(int unsigned i);
    logic [15:0] r;
    case (i)
      0:       r = 16'd32768;
      1:       r = 16'd19344;
      2:       r = 16'd10221;
      3:       r = 16'd5188;
      4:       r = 16'd2604;
      5:       r = 16'd1303;
      6:       r = 16'd652;
      7:       r = 16'd326;
      8:       r = 16'd163;
      9:       r = 16'd81;
      10:      r = 16'd41;
      11:      r = 16'd20;
      12:      r = 16'd10;
      13:      r = 16'd5;
      14:      r = 16'd3;
      15:      r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/psg_cordic_cell.sv
// ----------------------------------------------------------------------------
// psg_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the vector toward the x axis by the fixed angle of its step and
// accumulates that angle, then registers the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire             clk_i,
  input  wire             en_i,
  input  psg_pkg::cordic_t cell_i,
  output psg_pkg::cordic_t cell_o
);

  localparam logic [15:0] ATAN = psg_pkg::atan_q16(STEP);

  psg_pkg::cordic_t   nxt;
  logic signed [31:0] xs;
  logic signed [31:0] ys;

  // Rotate against the sign of y; a zero y stays put.
  always_comb begin
    xs  = cell_i.x >>> STEP;
    ys  = cell_i.y >>> STEP;
    nxt = cell_i;
    if (cell_i.y > 0) begin
      nxt.x = cell_i.x + ys;
      nxt.y = cell_i.y - xs;
      nxt.z = cell_i.z + $signed({2'b00, ATAN});
    end else if (cell_i.y < 0) begin
      nxt.x = cell_i.x - ys;
      nxt.y = cell_i.y + xs;
      nxt.z = cell_i.z - $signed({2'b00, ATAN});
    end
  end

  // Hand the result to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= nxt;
    end
  end

endmodule

`default_nettype wire

### sv/psg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psg_sqrt_cell: one digit of the integer square root
// Settles one root bit by a trial subtraction from the remaining radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire            clk_i,
  input  wire            en_i,
  input  psg_pkg::sqrt_t cell_i,
  output psg_pkg::sqrt_t cell_o
);

  localparam logic [29:0] BIT = 30'd1 << (28 - 2 * STEP);

  psg_pkg::sqrt_t nxt;
  logic [30:0]    trial;

  // Subtract root plus bit where it fits.
  always_comb begin
    trial = {1'b0, cell_i.root} + {1'b0, BIT};
    nxt   = cell_i;
    if ({1'b0, cell_i.rad} >= trial) begin
      nxt.rad  = cell_i.rad - trial[29:0];
      nxt.root = (cell_i.root >> 1) + BIT;
    end else begin
      nxt.root = cell_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= nxt;
    end
  end

endmodule

`default_nettype wire

### sv/psg_div_cell.sv
// ----------------------------------------------------------------------------
// psg_div_cell: one quotient bit of the attenuation divider
// Compares the partial remainder with the shifted divisor and sets one bit.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_div_cell #(
  parameter int unsigned STEP = 0
) (
  input  wire            clk_i,
  input  wire            en_i,
  input  psg_pkg::divq_t cell_i,
  output psg_pkg::divq_t cell_o
);

  localparam int unsigned QB = 15 - STEP;

  psg_pkg::divq_t nxt;
  logic [30:0]    trial;

  // Restoring step for quotient bit QB.
  always_comb begin
    trial = {16'd0, cell_i.dvsr} << QB;
    nxt   = cell_i;
    if ({4'd0, cell_i.rem} >= trial) begin
      nxt.rem     = cell_i.rem - trial[26:0];
      nxt.quo[QB] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= nxt;
    end
  end

endmodule

`default_nettype wire

### sv/positional_stereo_gain.sv
// ----------------------------------------------------------------------------
// positional_stereo_gain: left and right gains for a positioned sound source
// Rotates the source offset into listener space, attenuates by distance and
// pans by source angle, all in fixed point, through chains of small cells.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  input     in         in_valid_i / in_ready_o  volume_i, pos_x_i/y/z
//  output    out        out_valid_o/out_ready_i  left_gain_o, right_gain_o
//  config    in         cfg_we_i                 cfg_index_i, cfg_wdata_i
//
//  One source per cycle is taken while in_ready_o is high; each passes
//  through the square root and divider cell chains before its gains appear.
//  A two-entry output buffer lets the pipeline advance while a result waits.
//  The whole pipeline stalls only when that buffer is full and not drained.
//  Reset clears valid bits and buffer count and resets the config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_stereo_gain #(
  parameter int unsigned COORD_WIDTH = psg_pkg::COORD_WIDTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [psg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [COORD_WIDTH-1:0]            cfg_wdata_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [8:0]                        volume_i,
  input  wire  signed [COORD_WIDTH-1:0]     pos_x_i,
  input  wire  signed [COORD_WIDTH-1:0]     pos_y_i,
  input  wire  signed [COORD_WIDTH-1:0]     pos_z_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [15:0]                       left_gain_o,
  output logic [15:0]                       right_gain_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DEPTH = psg_pkg::PIPE_DEPTH;
  localparam int unsigned NCOR  = psg_pkg::CORDIC_STEPS;
  localparam int unsigned NSQ   = psg_pkg::SQRT_STEPS;
  localparam int unsigned NDIV  = psg_pkg::DIV_STEPS;
  localparam int unsigned NSB   = 39;
  localparam int unsigned NPAN  = 20;
  localparam int unsigned ND    = NDIV + 1;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
  } gains_t;

  // Configuration registers.
  logic signed [CW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [15:0]   cos_q, sin_q;

  // Pipeline control.
  logic             en;
  logic [DEPTH-1:0] vld_q;
  logic [1:0]       count_q;
  logic             push, pop;
  gains_t           ent_q [0:1];
  gains_t           res;

  // Front stages.
  logic signed [CW:0]    dx_q, dy_q, dz_q;
  logic                  np0_q;
  logic [16:0]           v00_q;
  logic [15:0]           npg0_q;
  logic [16:0]           v0_prod;
  logic [16:0]           npg_prod;
  logic signed [CW+16:0] pxc_q, pzs_q, pzc_q, pxs_q;
  logic [CW:0]           ady1_q, ady2_q;
  logic                  np1_q, np2_q;
  logic [16:0]           v01_q, v02_q;
  logic [15:0]           npg1_q, npg2_q;
  logic signed [CW+17:0] sx_q, sz_q;
  logic [CW+17:0]        sx_mag, sz_mag;
  logic [CW+2:0]         xa_full, zz_full;
  psg_pkg::sb_t          sb_new;
  logic [13:0]           xa3_q, zz3_q, ady3_q;
  logic [27:0]           sqx_q, sqy_q, sqz_q;
  logic [13:0]           or_v;
  logic [3:0]            msb;
  logic [4:0]            sh;

  // Chains and delay lines.
  psg_pkg::cordic_t cor_s [0:NCOR];
  psg_pkg::sqrt_t   sq_s  [0:NSQ];
  psg_pkg::divq_t   dv_s  [0:NDIV];
  psg_pkg::sb_t     sb_q  [0:NSB-1];
  psg_pkg::pan_t    pan_q [0:NPAN-1];
  logic signed [15:0] d_q [0:ND-1];
  logic signed [15:0] d_new;

  // Pan and attenuation stages.
  logic [16:0]  a_cl;
  logic [31:0]  pr1_q;
  logic [32:0]  pl1_q;
  logic [16:0]  k1_q, k1b_q;
  logic [27:0]  mul_q;
  logic         fade_q, kill_q, fade2_q, kill2_q;
  logic [54:0]  m2_q;
  logic [16:0]  kf_q;
  logic [33:0]  vk_q;
  logic [49:0]  gl_q;
  logic [50:0]  gr_q;
  logic         np_g, far_g, xpos_g;
  logic [15:0]  npg_g;
  logic [15:0]  gl_s, gr_s;
  logic signed [15:0] df;
  logic [11:0]        fw;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      cos_q   <= psg_pkg::VIEW_COS_RST;
      sin_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        psg_pkg::REG_CAMERA_X: cam_x_q <= cfg_wdata_i;
        psg_pkg::REG_CAMERA_Y: cam_y_q <= cfg_wdata_i;
        psg_pkg::REG_CAMERA_Z: cam_z_q <= cfg_wdata_i;
        psg_pkg::REG_VIEW_COS: cos_q   <= cfg_wdata_i[15:0];
        psg_pkg::REG_VIEW_SIN: sin_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless the output buffer is full and not drained.
  assign en         = (count_q != 2'd2) || out_ready_i;
  assign in_ready_o = en;
  assign push       = en && vld_q[DEPTH-1];
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Stage 0: offsets from the camera and volume products.
  assign v0_prod  = 17'(volume_i) * 17'd200;
  assign npg_prod = 17'(volume_i) * 17'd180;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= {pos_x_i[CW-1], pos_x_i} - {cam_x_q[CW-1], cam_x_q};
      dy_q   <= {pos_y_i[CW-1], pos_y_i} - {cam_y_q[CW-1], cam_y_q};
      dz_q   <= {pos_z_i[CW-1], pos_z_i} - {cam_z_q[CW-1], cam_z_q};
      np0_q  <= (pos_x_i == '0);
      v00_q  <= v0_prod;
      npg0_q <= npg_prod[16] ? 16'hFFFF : npg_prod[15:0];
    end
  end

  // Stage 1: rotation products and the vertical magnitude.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxc_q  <= dx_q * cos_q;
      pzs_q  <= dz_q * sin_q;
      pzc_q  <= dz_q * cos_q;
      pxs_q  <= dx_q * sin_q;
      ady1_q <= dy_q[CW] ? (CW+1)'(-dy_q) : (CW+1)'(dy_q);
      np1_q  <= np0_q;
      v01_q  <= v00_q;
      npg1_q <= npg0_q;
    end
  end

  // Stage 2: rotated components.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q   <= pxc_q + pzs_q;
      sz_q   <= pzc_q - pxs_q;
      ady2_q <= ady1_q;
      np2_q  <= np1_q;
      v02_q  <= v01_q;
      npg2_q <= npg1_q;
    end
  end

  // Stage 3: truncated magnitudes, far test and side of the source.
  always_comb begin
    sx_mag  = sx_q[CW+17] ? (CW+18)'(-sx_q) : (CW+18)'(sx_q);
    sz_mag  = sz_q[CW+17] ? (CW+18)'(-sz_q) : (CW+18)'(sz_q);
    xa_full = sx_mag[CW+17:15];
    zz_full = sz_mag[CW+17:15];
    sb_new.np   = np2_q;
    sb_new.v0   = v02_q;
    sb_new.npg  = npg2_q;
    sb_new.xpos = !sx_q[CW+17] && (xa_full != '0);
    sb_new.far  = (xa_full >= (CW+3)'(psg_pkg::FAR_LIMIT)) ||
                  (zz_full >= (CW+3)'(psg_pkg::FAR_LIMIT)) ||
                  (ady2_q >= (CW+1)'(psg_pkg::FAR_LIMIT));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa3_q  <= xa_full[13:0];
      zz3_q  <= zz_full[13:0];
      ady3_q <= ady2_q[13:0];
    end
  end

  // Side data delay line, stage 3 onward.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_new;
      for (int n = 1; n < NSB; n++) begin
        sb_q[n] <= sb_q[n-1];
      end
    end
  end

  // Stage 4: squares, and operand scaling for the angle.
  always_comb begin
    or_v = xa3_q | zz3_q;
    msb  = '0;
    for (int b = 0; b < 14; b++) begin
      if (or_v[b]) begin
        msb = 4'(b);
      end
    end
    sh = 5'd28 - {1'b0, msb};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q      <= xa3_q * xa3_q;
      sqy_q      <= ady3_q * ady3_q;
      sqz_q      <= zz3_q * zz3_q;
      cor_s[0].x <= $signed(32'(zz3_q) << sh);
      cor_s[0].y <= $signed(32'(xa3_q) << sh);
      cor_s[0].z <= '0;
    end
  end

  // Stage 5: radicand.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_s[0].rad  <= 30'(sqx_q) + 30'(sqy_q) + 30'(sqz_q);
      sq_s[0].root <= '0;
    end
  end

  // Angle chain.
  for (genvar c = 0; c < NCOR; c++) begin : g_cordic
    psg_cordic_cell #(.STEP(c)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (cor_s[c]),
      .cell_o (cor_s[c+1])
    );
  end

  // Square root chain.
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    psg_sqrt_cell #(.STEP(j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (sq_s[j]),
      .cell_o (sq_s[j+1])
    );
  end

  // Pan factors: clamp the angle, then scale it.
  always_comb begin
    if (cor_s[NCOR].z < 0) begin
      a_cl = '0;
    end else if (cor_s[NCOR].z > 18'sd65536) begin
      a_cl = 17'd65536;
    end else begin
      a_cl = cor_s[NCOR].z[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr1_q <= 32'(a_cl) * 32'(psg_pkg::PAN_RIGHT);
      pl1_q <= 33'(a_cl) * 33'(psg_pkg::PAN_LEFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pan_q[0].rq <= 17'(psg_pkg::PAN_BASE) + {1'b0, pr1_q[31:16]};
      pan_q[0].lq <= psg_pkg::PAN_BASE - pl1_q[31:16];
      for (int n = 1; n < NPAN; n++) begin
        pan_q[n] <= pan_q[n-1];
      end
    end
  end

  // Divider setup: distance less 512 and the divisor.
  assign d_new = $signed({1'b0, sq_s[NSQ].root[14:0]}) - 16'sd512;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_s[0].rem  <= psg_pkg::ATTEN_NUM;
      dv_s[0].quo  <= '0;
      dv_s[0].dvsr <= (d_new > 0) ? 15'(16'sd1224 + d_new) : 15'd1224;
      d_q[0]       <= d_new;
      for (int n = 1; n < ND; n++) begin
        d_q[n] <= d_q[n-1];
      end
    end
  end

  // Attenuation divider chain.
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    psg_div_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .cell_i (dv_s[i]),
      .cell_o (dv_s[i+1])
    );
  end

  // Far fade: scale by (10000 - d) / 4000 between 6000 and 10000.
  assign df = d_q[ND-1];
  assign fw = 12'(16'sd10000 - df);

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q   <= (df <= 0) ? 17'd65536 : {1'b0, dv_s[NDIV].quo};
      fade_q <= (df > 16'sd6000);
      kill_q <= (df >= 16'sd10000);
      mul_q  <= dv_s[NDIV].quo * fw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q    <= 55'(mul_q) * 55'(psg_pkg::RECIP_4000);
      k1b_q   <= k1_q;
      fade2_q <= fade_q;
      kill2_q <= kill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (kill2_q) begin
        kf_q <= '0;
      end else if (fade2_q) begin
        kf_q <= m2_q[54:psg_pkg::RECIP_SHIFT];
      end else begin
        kf_q <= k1b_q;
      end
    end
  end

  // Gain products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      vk_q <= 34'(sb_q[NSB-2].v0) * 34'(kf_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gl_q   <= 50'(vk_q) * 50'(pan_q[NPAN-1].lq);
      gr_q   <= 51'(vk_q) * 51'(pan_q[NPAN-1].rq);
      np_g   <= sb_q[NSB-1].np;
      far_g  <= sb_q[NSB-1].far;
      xpos_g <= sb_q[NSB-1].xpos;
      npg_g  <= sb_q[NSB-1].npg;
    end
  end

  // Saturate and route the gains; np sources take npg_g and far ones are silent.
  always_comb begin
    gl_s = (gl_q[49:48] != '0) ? 16'hFFFF : gl_q[47:32];
    gr_s = (gr_q[50:48] != '0) ? 16'hFFFF : gr_q[47:32];
    if (np_g) begin
      res.left  = npg_g;
      res.right = npg_g;
    end else if (far_g) begin
      res.left  = '0;
      res.right = '0;
    end else if (xpos_g) begin
      res.left  = gl_s;
      res.right = gr_s;
    end else begin
      res.left  = gr_s;
      res.right = gl_s;
    end
  end

  // Two-entry output buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case ({push, pop})
      2'b10: begin
        if (count_q == 2'd0) begin
          ent_q[0] <= res;
        end else begin
          ent_q[1] <= res;
        end
      end
      2'b01: begin
        ent_q[0] <= ent_q[1];
      end
      2'b11: begin
        if (count_q == 2'd1) begin
          ent_q[0] <= res;
        end else begin
          ent_q[0] <= ent_q[1];
          ent_q[1] <= res;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = (count_q != 2'd0);
  assign left_gain_o  = ent_q[0].left;
  assign right_gain_o = ent_q[0].right;

  // Checks on the buffer and the arithmetic ranges.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2 && !out_ready_i) |=> !$past(push))
    else $error("transaction pushed into a full output buffer");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[20] && !sb_q[17].np && !sb_q[17].far) |-> (sq_s[NSQ].root <= 30'd18207))
    else $error("distance beyond the near range");

  a_pan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[22] |-> (pan_q[0].lq <= psg_pkg::PAN_BASE && pan_q[0].rq <= 17'd65536 &&
                   pan_q[0].rq >= 17'(psg_pkg::PAN_BASE)))
    else $error("pan factors out of range");

endmodule

`default_nettype wire
